// File: hdl/sem_pkg.sv
// Shared constants and controller/datapath interface types for the Sobel edge block.
package sem_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int CH_W          = 8;
   localparam int NUM_CH        = 3;
   localparam int PIX_W         = CH_W * NUM_CH;
   localparam int CFG_W         = 11;
   localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;
   localparam int GRAD_W        = 11;
   localparam int SUM_W         = 21;
   localparam int STEP_W        = 3;

   typedef struct packed {
      logic shift_data;
      logic shift_zero;
      logic grad;
      logic sq;
      logic mag_step;
      logic out_load;
      logic out_last;
      logic out_fend;
   } cmd_type;

   typedef struct packed {
      logic emit_first;
      logic row_end;
      logic active;
      logic flush;
      logic mag_last;
      logic rsp_taken;
   } sts_type;

endpackage

// File: hdl/sem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sem_ram
   #(parameter int WIDTH = 24,
     parameter int DEPTH = 1024,
     localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sem_ctrl.sv
// Controller state machine: sequences one input transfer through shift, gradient and output.
module sem_ctrl
   import sem_pkg::*;
   (input  logic    clock,
    input  logic    reset,
    input  logic    accept,
    input  sts_type sts,
    output cmd_type cmd,
    output logic    ready);

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_ZS, S_GRAD, S_SQ, S_MAG, S_OUTW
   } state_type;

   state_type state_ff;
   cmd_type   cmd_ff;
   logic      ready_ff;
   logic      phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmd_ff   <= '0;
         ready_ff <= 1'b1;
         phase_ff <= 1'b0;
      end else begin
         cmd_ff <= '0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ready_ff          <= 1'b0;
                  phase_ff          <= 1'b0;
                  state_ff          <= S_RD;
                  cmd_ff.shift_data <= 1'b1;
               end
            end
            S_RD: begin
               if (sts.emit_first) begin
                  state_ff    <= S_GRAD;
                  cmd_ff.grad <= 1'b1;
               end else if (sts.row_end) begin
                  state_ff          <= S_ZS;
                  cmd_ff.shift_zero <= 1'b1;
               end else begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_ZS: begin
               phase_ff <= 1'b1;
               if (sts.active) begin
                  state_ff    <= S_GRAD;
                  cmd_ff.grad <= 1'b1;
               end else begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_GRAD: begin
               state_ff  <= S_SQ;
               cmd_ff.sq <= 1'b1;
            end
            S_SQ: begin
               state_ff        <= S_MAG;
               cmd_ff.mag_step <= 1'b1;
            end
            S_MAG: begin
               if (sts.mag_last) begin
                  state_ff        <= S_OUTW;
                  cmd_ff.out_load <= 1'b1;
                  cmd_ff.out_last <= phase_ff | ~sts.row_end;
                  cmd_ff.out_fend <= phase_ff & sts.flush;
               end else begin
                  cmd_ff.mag_step <= 1'b1;
               end
            end
            S_OUTW: begin
               if (sts.rsp_taken) begin
                  if (!phase_ff && sts.row_end) begin
                     state_ff          <= S_ZS;
                     cmd_ff.shift_zero <= 1'b1;
                  end else begin
                     state_ff <= S_IDLE;
                     ready_ff <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign cmd   = cmd_ff;
   assign ready = ready_ff;

endmodule

// File: hdl/sem_datapath.sv
// Datapath: line stores, 3x3 window, gradients, squares, bitwise magnitude search, result register.
module sem_datapath
   import sem_pkg::*;
   #(parameter int MAX_WIDTH = MAX_WIDTH_DEF)
   (input  logic              clock,
    input  logic              reset,
    input  logic              accept,
    input  logic [PIX_W-1:0]  pixel,
    input  logic              flush,
    input  logic              csr_wr_en,
    input  logic [CFG_W-1:0]  csr_wr_data,
    input  cmd_type           cmd,
    output sts_type           sts,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic [PIX_W-1:0]  rsp_data,
    output logic              rsp_last,
    output logic              rsp_fend);

   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int LW  = 13;
   localparam logic [LW-1:0] MAX_W = LW'(MAX_WIDTH);

   logic [CFG_W-1:0] width_ff;
   logic [CW-1:0]    col_ff, c_ff;
   logic [1:0]       rows_ff;
   logic [PIX_W-1:0] px_ff;
   logic             fl_ff, row_end_ff, active_ff, top_en_ff;
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] above_rd, center_rd;
   logic [LW-1:0]    wlim;
   logic             row_end_now;

   logic signed [GRAD_W-1:0] gx_ff [NUM_CH];
   logic signed [GRAD_W-1:0] gy_ff [NUM_CH];
   logic [SUM_W-1:0]         s_ff  [NUM_CH];
   logic [CH_W-1:0]          n_ff  [NUM_CH];
   logic [STEP_W-1:0]        step_ff;
   logic                     valid_ff, last_ff, fend_ff;
   logic [PIX_W-1:0]         data_ff;

   always_comb begin
      if (width_ff == '0) begin
         wlim = LW'(1);
      end else if (LW'(width_ff) > MAX_W) begin
         wlim = MAX_W;
      end else begin
         wlim = LW'(width_ff);
      end
   end
   assign row_end_now = LW'(col_ff) >= (wlim - LW'(1));

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
      .clock   (clock),
      .wr_en   (cmd.shift_data),
      .wr_addr (c_ff),
      .wr_data (center_rd),
      .rd_addr (col_ff),
      .rd_data (above_rd));

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_center (
      .clock   (clock),
      .wr_en   (cmd.shift_data),
      .wr_addr (c_ff),
      .wr_data (px_ff),
      .rd_addr (col_ff),
      .rd_data (center_rd));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         col_ff   <= '0;
         rows_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         if (accept) begin
            if (row_end_now) begin
               col_ff <= '0;
               if (flush) begin
                  rows_ff <= 2'd0;
               end else if (rows_ff != 2'd2) begin
                  rows_ff <= rows_ff + 2'd1;
               end
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
         if (cmd.out_load) begin
            valid_ff <= 1'b1;
         end else if (valid_ff && rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // per-item latches and window
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff      <= flush ? '0 : pixel;
         fl_ff      <= flush;
         c_ff       <= col_ff;
         row_end_ff <= row_end_now;
         active_ff  <= rows_ff != 2'd0;
         top_en_ff  <= rows_ff == 2'd2;
      end
      if (cmd.shift_data) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= (c_ff == '0) ? '0 : win_ff[r][1];
            win_ff[r][1] <= (c_ff == '0) ? '0 : win_ff[r][2];
         end
         win_ff[0][2] <= top_en_ff ? above_rd : '0;
         win_ff[1][2] <= active_ff ? center_rd : '0;
         win_ff[2][2] <= px_ff;
      end else if (cmd.shift_zero) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
            win_ff[r][2] <= '0;
         end
      end
   end

   // gradients, squares and magnitude, one lane per channel
   always_ff @(posedge clock) begin
      logic [9:0]        pa, pb, qa, qb;
      logic [CH_W-1:0]   t, tm1;
      logic [2*CH_W-1:0] prod;
      logic signed [2*GRAD_W-1:0] sqx, sqy;
      for (int k = 0; k < NUM_CH; k++) begin
         pa = 10'(win_ff[0][2][k*CH_W +: CH_W]) + 10'({win_ff[1][2][k*CH_W +: CH_W], 1'b0})
            + 10'(win_ff[2][2][k*CH_W +: CH_W]);
         pb = 10'(win_ff[0][0][k*CH_W +: CH_W]) + 10'({win_ff[1][0][k*CH_W +: CH_W], 1'b0})
            + 10'(win_ff[2][0][k*CH_W +: CH_W]);
         qa = 10'(win_ff[2][0][k*CH_W +: CH_W]) + 10'({win_ff[2][1][k*CH_W +: CH_W], 1'b0})
            + 10'(win_ff[2][2][k*CH_W +: CH_W]);
         qb = 10'(win_ff[0][0][k*CH_W +: CH_W]) + 10'({win_ff[0][1][k*CH_W +: CH_W], 1'b0})
            + 10'(win_ff[0][2][k*CH_W +: CH_W]);
         sqx  = gx_ff[k] * gx_ff[k];
         sqy  = gy_ff[k] * gy_ff[k];
         t    = n_ff[k] | (CH_W'(1) << step_ff);
         tm1  = t - CH_W'(1);
         prod = t * tm1;
         if (cmd.grad) begin
            gx_ff[k] <= $signed({1'b0, pa}) - $signed({1'b0, pb});
            gy_ff[k] <= $signed({1'b0, qa}) - $signed({1'b0, qb});
         end
         if (cmd.sq) begin
            s_ff[k] <= SUM_W'(sqx) + SUM_W'(sqy);
            n_ff[k] <= '0;
         end else if (cmd.mag_step) begin
            if (SUM_W'(prod) < s_ff[k]) begin
               n_ff[k] <= t;
            end
         end
      end
      if (cmd.sq) begin
         step_ff <= '1;
      end else if (cmd.mag_step) begin
         step_ff <= step_ff - STEP_W'(1);
      end
      if (cmd.out_load) begin
         data_ff <= {n_ff[2], n_ff[1], n_ff[0]};
         last_ff <= cmd.out_last;
         fend_ff <= cmd.out_fend;
      end
   end

   assign sts.emit_first = active_ff && (c_ff != '0);
   assign sts.row_end    = row_end_ff;
   assign sts.active     = active_ff;
   assign sts.flush      = fl_ff;
   assign sts.mag_last   = step_ff == '0;
   assign sts.rsp_taken  = valid_ff && rsp_ready;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   assign rsp_last  = last_ff;
   assign rsp_fend  = fend_ff;

endmodule

// File: hdl/sobel_edge_magnitude_rgb.sv
// Top level of the streaming RGB Sobel edge magnitude block.
//  channel | direction | content
//  req_*   | in        | tdata: pixel_blue, pixel_green, pixel_red; tuser: flush
//  rsp_*   | out       | tdata: edge_blue, edge_green, edge_red; tlast: last_of_run;
//          |           | tuser: frame_end
//  csr_*   | in        | image_width write, no read-back
// One input transfer at a time. An item that emits nothing passes only the read state; a row
// end adds the zero shift; each result adds gradient, square, 8-step magnitude search and
// output, plus any rsp stall.
// Line store data is read at acceptance and used in the following cycle (registered RAM read).
// Synchronous reset; line stores are not cleared, no clearing pass.
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
   #(parameter int MAX_WIDTH = MAX_WIDTH_DEF)
   (input  logic             clock,
    input  logic             reset,
    input  logic             req_tvalid,
    output logic             req_tready,
    input  logic [PIX_W-1:0] req_tdata,   // blue, green, red
    input  logic [0:0]       req_tuser,   // flush
    output logic             rsp_tvalid,
    input  logic             rsp_tready,
    output logic [PIX_W-1:0] rsp_tdata,   // edge_blue, edge_green, edge_red
    output logic             rsp_tlast,
    output logic [0:0]       rsp_tuser,   // frame_end
    input  logic             csr_wr_en,
    input  logic [CFG_W-1:0] csr_wr_data);

   cmd_type cmd;
   sts_type sts;
   logic    accept;
   logic    ready;

   assign accept     = req_tvalid && ready;
   assign req_tready = ready;

   sem_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sts    (sts),
      .cmd    (cmd),
      .ready  (ready));

   sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel       (req_tdata),
      .flush       (req_tuser[0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_data    (rsp_tdata),
      .rsp_last    (rsp_tlast),
      .rsp_fend    (rsp_tuser[0]));

endmodule

// File: hdl/sem_checker.sv
// Port-level checks for the Sobel edge block, bound to the top level.
module sem_checker
   (input logic clock,
    input logic reset,
    input logic req_tvalid,
    input logic req_tready,
    input logic rsp_tvalid,
    input logic rsp_tready,
    input logic rsp_tlast,
    input logic [0:0] rsp_tuser);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transfer dropped while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a result waits");

   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end not on last result of item");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser));

// File: tb/sv/tb.sv
// Self-checking testbench for the streaming RGB Sobel edge magnitude block.
module tb;
   import sem_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             flush;
   } pixel_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] edges;
      logic             last;
      logic             fend;
   } edge_result_type;

   localparam int LIMIT_CYCLES = 4000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [PIX_W-1:0] req_tdata = '0;
   logic [0:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [PIX_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic [0:0]       rsp_tuser;
   logic             csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   sobel_edge_magnitude_rgb u_dut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [PIX_W-1:0] line_above [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] line_mid [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] win [9];
   int               col;
   int               rows;
   int               width_reg;

   pixel_item_type  pixel_queue[$];
   edge_result_type edge_queue[$];
   int              errors = 0;
   int              send_idle = 0;  // percent
   int              recv_stall = 0;
   longint          cycles = 0;

   function automatic logic [7:0] sobel_mag(int unsigned s);
      logic [8:0] n;
      int unsigned t;
      n = '0;
      for (int b = 7; b >= 0; b--) begin
         t = n | (1 << b);
         if (t * (t - 1) < s) n = 9'(t);
      end
      return n[7:0];
   endfunction

   function automatic edge_result_type window_edges(logic last, logic fend);
      edge_result_type r;
      int tl, tm, tr, ml, mr, bl, bm, br, gx, gy;
      for (int c = 0; c < 3; c++) begin
         tl = int'(win[0][8*c+:8]); tm = int'(win[1][8*c+:8]); tr = int'(win[2][8*c+:8]);
         ml = int'(win[3][8*c+:8]); mr = int'(win[5][8*c+:8]);
         bl = int'(win[6][8*c+:8]); bm = int'(win[7][8*c+:8]); br = int'(win[8][8*c+:8]);
         gx = (tr + 2*mr + br) - (tl + 2*ml + bl);
         gy = (bl + 2*bm + br) - (tl + 2*tm + tr);
         r.edges[8*c+:8] = sobel_mag(gx*gx + gy*gy);
      end
      r.last = last;
      r.fend = fend;
      return r;
   endfunction

   function automatic void window_shift(logic [PIX_W-1:0] t, m, b);
      for (int r = 0; r < 3; r++) begin
         win[3*r] = win[3*r+1];
         win[3*r+1] = win[3*r+2];
      end
      win[2] = t; win[5] = m; win[8] = b;
   endfunction

   function automatic void predict_edges(pixel_item_type it);
      int w;
      logic [PIX_W-1:0] px, top, mid;
      logic row_end, active;
      w = width_reg == 0 ? 1 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width_reg);
      px = it.flush ? '0 : it.pix;
      top = '0; mid = '0;
      row_end = col >= w - 1;
      active = rows >= 1;
      if (col == 0) foreach (win[i]) win[i] = '0;
      if (active) mid = line_mid[col];
      if (rows >= 2) top = line_above[col];
      line_above[col] = line_mid[col];
      line_mid[col] = px;
      window_shift(top, mid, px);
      if (active && col >= 1) edge_queue.push_back(window_edges(!row_end, 1'b0));
      if (row_end) begin
         window_shift('0, '0, '0);
         if (active) edge_queue.push_back(window_edges(1'b1, it.flush));
         col = 0;
         if (it.flush) rows = 0;
         else if (rows < 2) rows++;
      end else begin
         col++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_tvalid <= 1'b1;
            req_tdata <= pixel_queue[0].pix;
            req_tuser <= pixel_queue[0].flush;
            predict_edges(pixel_queue.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      edge_result_type exp_r;
      cycles <= cycles + 1;
      if (!reset) rsp_tready <= $urandom_range(99) >= recv_stall;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (edge_queue.size() == 0) begin
            $display("%0t: unexpected result %h last %b fend %b", $time, rsp_tdata,
                     rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            exp_r = edge_queue.pop_front();
            if (rsp_tdata !== exp_r.edges)
               $display("%0t: edges expected %h actual %h", $time, exp_r.edges, rsp_tdata);
            if (rsp_tlast !== exp_r.last)
               $display("%0t: tlast expected %b actual %b", $time, exp_r.last, rsp_tlast);
            if (rsp_tuser[0] !== exp_r.fend)
               $display("%0t: tuser expected %b actual %b", $time, exp_r.fend, rsp_tuser);
            if (rsp_tdata !== exp_r.edges || rsp_tlast !== exp_r.last ||
                rsp_tuser[0] !== exp_r.fend)
               errors++;
         end
      end
      if (cycles > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [PIX_W-1:0] rand_pix(int mode);
      case (mode)
         0: return '0;
         1: return '1;
         2: return {$urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00,
                    $urandom_range(1) ? 8'hff : 8'h00};
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // one frame: rows of pixels then a flush row
   task automatic queue_frame(int w, int nrows, int mode);
      pixel_item_type it;
      for (int r = 0; r < nrows; r++)
         for (int c = 0; c < w; c++) begin
            it.flush = 1'b0;
            it.pix = rand_pix(mode == 4 ? $urandom_range(3) : mode);
            // occasional flush sample inside a pixel row, row end kept as pixel
            if (mode == 4 && c != w - 1 && $urandom_range(15) == 0) it.flush = 1'b1;
            pixel_queue.push_back(it);
         end
      for (int c = 0; c < w; c++) begin
         it.flush = 1'b1;
         it.pix = PIX_W'($urandom);
         if (mode == 4 && c != w - 1 && $urandom_range(7) == 0) begin
            it.flush = 1'b0;
         end
         pixel_queue.push_back(it);
      end
   endtask

   task automatic drain_and_set_width(int w);
      while (pixel_queue.size() != 0 || req_tvalid || edge_queue.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CFG_W'(w);
      width_reg = w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_phase(int ph);
      case (ph % 4)
         0: begin send_idle = 0;  recv_stall = 0;  end
         1: begin send_idle = 88; recv_stall = 0;  end
         2: begin send_idle = 0;  recv_stall = 88; end
         default: begin send_idle = 25; recv_stall = 25; end
      endcase
   endtask

   initial begin
      int sent, w, ph;
      pixel_item_type it;
      col = 0; rows = 0; width_reg = int'(WIDTH_RESET);
      foreach (win[i]) win[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: width 1, extremes, flush before any row, full-swing patterns
      drain_and_set_width(1);
      it.flush = 1'b1; it.pix = '1;
      pixel_queue.push_back(it);
      queue_frame(1, 3, 1);
      drain_and_set_width(3);
      queue_frame(3, 1, 2);
      queue_frame(3, 2, 1);
      drain_and_set_width(2);
      queue_frame(2, 2, 0);

      // one wide frame
      drain_and_set_width(160);
      queue_frame(160, 1, 3);

      // width above the maximum: no row end within a short run, then a
      // width-1 flush item closes the partial row and realigns the frames
      drain_and_set_width(2047);
      queue_frame(4, 1, 3);
      drain_and_set_width(1);
      it.flush = 1'b1; it.pix = '0;
      pixel_queue.push_back(it);

      sent = 0;
      ph = 0;
      while (sent < 1350) begin
         set_phase(ph);
         w = ($urandom_range(9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
         drain_and_set_width(w);
         for (int f = 0; f < 3; f++) begin
            int nr;
            nr = $urandom_range(1, 5);
            queue_frame(w, nr, $urandom_range(4));
            sent += w * (nr + 1);
         end
         ph++;
      end
      drain_and_set_width(0);
      queue_frame(1, 2, 3);

      while (pixel_queue.size() != 0 || req_tvalid || edge_queue.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && edge_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
